>>> rtl/core/frame_buffer_rotation_manager_top_assert.svh
// Assertion macros shared by the frame buffer rotation manager checkers.
// Expects signals clk_i and rst_ni in the scope of each use.
`ifndef FRAME_BUFFER_ROTATION_MANAGER_TOP_ASSERT_SVH
`define FRAME_BUFFER_ROTATION_MANAGER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset
`define FBRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define FBRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/fbrm_pkg.sv
// Package for the frame buffer rotation manager: pool size, opcodes,
// sequencer states, result struct and pointer helpers. No dependencies.
`timescale 1ns / 1ps

package fbrm_pkg;

  // Pool size and derived widths
  localparam int FRAME_COUNT = 3;
  localparam int FRM_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int IDX_W       = 4;
  localparam int OP_W        = 2;

  localparam logic [FRM_W-1:0] FRM_LAST = FRM_W'(FRAME_COUNT - 1);

  typedef enum logic [OP_W-1:0] {
    OP_CAPTURE = 2'd0,
    OP_PROCESS = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_RELEASE = 2'd3
  } fbrm_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } fbrm_state_e;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] index;
  } fbrm_res_t;

  // Step a frame pointer forward with wraparound
  function automatic logic [FRM_W-1:0] fbrm_next(input logic [FRM_W-1:0] p);
    logic [FRM_W-1:0] r;
    r = (p == FRM_LAST) ? '0 : p + FRM_W'(1);
    return r;
  endfunction

  // Step a frame pointer back with wraparound
  function automatic logic [FRM_W-1:0] fbrm_prev(input logic [FRM_W-1:0] p);
    logic [FRM_W-1:0] r;
    r = (p == '0) ? FRM_LAST : p - FRM_W'(1);
    return r;
  endfunction

endpackage

>>> rtl/core/fbrm_engine.sv
// Lock table and request sequencer of the frame buffer rotation manager.
// One lock-bit probe per cycle under a small state machine; uses fbrm_pkg.
`timescale 1ns / 1ps

module fbrm_engine import fbrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  fbrm_op_e         req_op_i,
  input  logic [IDX_W-1:0] req_index_i,
  output logic             req_ready_o,
  output logic             res_valid_o,
  output fbrm_res_t        res_o,
  input  logic             res_ready_i
);

  fbrm_state_e state_q, state_d;
  fbrm_op_e    op_q, op_d;
  logic [FRM_W-1:0] ptr_q, ptr_d;
  logic [FRM_W-1:0] cnt_q, cnt_d;
  logic [FRM_W-1:0] cap_q, cap_d;
  logic [FRM_W-1:0] proc_q, proc_d;
  logic [FRAME_COUNT-1:0] lock_q, lock_d;
  fbrm_res_t res_q, res_d;
  logic hit;
  logic in_range;

  // Shared probe: lock bit of the frame under the pointer
  assign hit      = lock_q[ptr_q];
  assign in_range = {1'b0, req_index_i} < (IDX_W + 1)'(FRAME_COUNT);

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold pool state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= '0;
      cap_q  <= '0;
      proc_q <= '0;
      op_q   <= OP_CAPTURE;
      ptr_q  <= '0;
      cnt_q  <= '0;
    end else begin
      lock_q <= lock_d;
      cap_q  <= cap_d;
      proc_q <= proc_d;
      op_q   <= op_d;
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Next state and datapath control
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    cap_d   = cap_q;
    proc_d  = proc_q;
    lock_d  = lock_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_op_i;
          cnt_d   = '0;
          state_d = ST_SCAN;
          unique case (req_op_i)
            OP_CAPTURE: ptr_d = cap_q;
            OP_PROCESS: ptr_d = fbrm_prev(cap_q);
            OP_DISPLAY: ptr_d = proc_q;
            OP_RELEASE: begin
              if (in_range) begin
                ptr_d = req_index_i[FRM_W-1:0];
              end else begin
                res_d   = '0;
                state_d = ST_HOLD;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        state_d = ST_HOLD;
        res_d   = '{granted: 1'b1, index: IDX_W'(ptr_q)};
        unique case (op_q)
          OP_CAPTURE: begin
            // Walk round-robin until a free frame turns up
            if (!hit) begin
              lock_d[ptr_q] = 1'b1;
              cap_d         = fbrm_next(ptr_q);
            end else if (cnt_q == FRM_LAST) begin
              res_d = '0;
            end else begin
              ptr_d   = fbrm_next(ptr_q);
              cnt_d   = cnt_q + FRM_W'(1);
              state_d = ST_SCAN;
            end
          end
          OP_PROCESS: begin
            if (hit) begin
              proc_d = ptr_q;
            end else begin
              res_d = '0;
            end
          end
          OP_DISPLAY: begin
            if (!hit) begin
              res_d = '0;
            end
          end
          OP_RELEASE: lock_d[ptr_q] = 1'b0;
          default: res_d = '0;
        endcase
      end
      ST_HOLD: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_HOLD);
  assign res_o       = res_q;

endmodule

>>> rtl/core/frame_buffer_rotation_manager_top.sv
// Frame buffer rotation manager: frame pool lock manager with stream ports.
// Channels:
//   s_axis  request transfer; tuser = opcode (0 capture, 1 process,
//           2 display, 3 release), tdata = frame index for release.
//   m_axis  result transfer; tuser = granted, tdata = granted frame index.
// Every request yields exactly one result, in request order.
// Requests are taken one at a time: a new one only once the sequencer is
// back in idle. A capture probes one lock bit per cycle round-robin from the
// capture pointer, so its scan probes 1 to FRAME_COUNT frames; process,
// display and release take one probe, an out-of-range release none. The
// sequencer then holds the result until the output register takes it, which
// raises m_axis_tvalid, and returns to idle.
// Reset clears all lock bits and both frame pointers and empties the
// output register; the block is ready right after reset.
// A stalled receiver holds the result in the output register; the next
// request is still taken and worked on, and its result waits in the
// sequencer until the output register frees up.
// Uses fbrm_pkg and fbrm_engine.
`timescale 1ns / 1ps

module frame_buffer_rotation_manager_top import fbrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] frame_index, [7:4] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] granted_index, [7:4] zero
  output logic [0:0] m_axis_tuser    // [0] granted
);

  logic      res_valid;
  logic      res_ready;
  fbrm_res_t res;
  logic      out_valid_q, out_valid_d;
  fbrm_res_t out_res_q;

  fbrm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_op_i    (fbrm_op_e'(s_axis_tuser)),
    .req_index_i (s_axis_tdata[IDX_W-1:0]),
    .req_ready_o (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Take a new result when the output register is empty or draining
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output payload on each result transfer
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 8'(out_res_q.index);
  assign m_axis_tuser  = out_res_q.granted;

endmodule

>>> rtl/core/fbrm_checker.sv
// Port-level checker for the frame buffer rotation manager, bound to the top.
// Uses fbrm_pkg and frame_buffer_rotation_manager_top_assert.svh.
`timescale 1ns / 1ps

`include "frame_buffer_rotation_manager_top_assert.svh"

module fbrm_checker import fbrm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [0:0] m_axis_tuser
);

  // Stalled result holds its payload
  `FBRM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // A refused request carries index zero
  `FBRM_ASSERT(a_deny_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0, "denied result with nonzero index")

  // A granted index lies inside the pool
  `FBRM_ASSERT(a_grant_range, m_axis_tvalid && m_axis_tuser[0] |-> {4'd0, m_axis_tdata} < 12'(FRAME_COUNT), "granted index out of pool")

  // One request at a time: ready drops after each request transfer
  `FBRM_ASSERT(a_one_at_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")

  // No result is offered in reset
  `FBRM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind frame_buffer_rotation_manager_top fbrm_checker u_fbrm_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for frame_buffer_rotation_manager_top: directed and random
// capture, process, display and release requests, with a lock-state predictor per transfer.
// Depends on fbrm_pkg and the frame_buffer_rotation_manager_top RTL.
`timescale 1ns / 1ps

module tb;
  import fbrm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int ITEMS_PER_PHASE = 650;

  typedef struct {
    bit       granted;
    bit [3:0] index;
  } grant_t;

  // Tracks frame locks and pointers, and checks each result transfer in order
  class grant_scoreboard;
    bit       frame_locked[FRAME_COUNT];
    bit [3:0] capture_ptr;
    bit [3:0] process_ptr;
    grant_t   expected_grants[$];
    int       mismatch_count;
    int       result_count;

    function new();
      for (int i = 0; i < FRAME_COUNT; i++) frame_locked[i] = 1'b0;
      capture_ptr    = '0;
      process_ptr    = '0;
      mismatch_count = 0;
      result_count   = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    // Work out the grant for one accepted request and update lock state
    function grant_t predict_grant(input fbrm_op_e op, input bit [3:0] frame_sel);
      grant_t g;
      int     idx;
      g.granted = 1'b0;
      g.index   = '0;
      case (op)
        OP_CAPTURE: begin
          for (int i = 0; i < FRAME_COUNT; i++) begin
            idx = (int'(capture_ptr) % FRAME_COUNT + i) % FRAME_COUNT;
            if (!g.granted && !frame_locked[idx]) begin
              frame_locked[idx] = 1'b1;
              capture_ptr = 4'((idx + 1) % FRAME_COUNT);
              g.granted = 1'b1;
              g.index   = 4'(idx);
            end
          end
        end
        OP_PROCESS: begin
          idx = (int'(capture_ptr) % FRAME_COUNT + FRAME_COUNT - 1) % FRAME_COUNT;
          if (frame_locked[idx]) begin
            process_ptr = 4'(idx);
            g.granted = 1'b1;
            g.index   = 4'(idx);
          end
        end
        OP_DISPLAY: begin
          idx = int'(process_ptr) % FRAME_COUNT;
          if (frame_locked[idx]) begin
            g.granted = 1'b1;
            g.index   = 4'(idx);
          end
        end
        default: begin
          if (int'(frame_sel) < FRAME_COUNT) begin
            frame_locked[frame_sel] = 1'b0;
            g.granted = 1'b1;
            g.index   = frame_sel;
          end
        end
      endcase
      return g;
    endfunction

    function void note_request(input fbrm_op_e op, input bit [3:0] frame_sel);
      expected_grants.push_back(predict_grant(op, frame_sel));
    endfunction

    task check_result(input bit granted, input logic [7:0] data);
      grant_t g;
      result_count++;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result granted=%0d data=%h", granted, data));
      end else begin
        g = expected_grants.pop_front();
        if (granted !== g.granted)
          report_mismatch($sformatf("result %0d granted %0d, want %0d",
                                    result_count, granted, g.granted));
        if (data !== {4'b0000, g.index})
          report_mismatch($sformatf("result %0d tdata %h, want %h",
                                    result_count, data, {4'b0000, g.index}));
      end
    endtask

    function int pending();
      return expected_grants.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  grant_scoreboard board = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int idle_cycles = 0;

  frame_buffer_rotation_manager_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one request and hold it until the transfer completes
  task automatic send_request(input fbrm_op_e op, input bit [3:0] frame_sel);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, frame_sel};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(op, frame_sel);
    @(negedge clk_i);
  endtask

  // Random request: releases are mostly in range so the pool keeps turning over
  task automatic send_random_request();
    int       pick;
    fbrm_op_e op;
    bit [3:0] frame_sel;
    pick = $urandom_range(99);
    if (pick < 30)      op = OP_CAPTURE;
    else if (pick < 50) op = OP_PROCESS;
    else if (pick < 70) op = OP_DISPLAY;
    else                op = OP_RELEASE;
    if (op == OP_RELEASE && $urandom_range(99) < 80)
      frame_sel = 4'($urandom_range(FRAME_COUNT - 1));
    else
      frame_sel = 4'($urandom_range(15));
    send_request(op, frame_sel);
  endtask

  // Result receiver; one long hold-off early on to back up the block
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (!hold_done && board.result_count >= 100) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        @(negedge clk_i);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser[0], m_axis_tdata);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_CAPTURE;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty pool, fill it, overflow, out-of-range and repeat releases
    send_request(OP_DISPLAY, 4'h0);
    send_request(OP_PROCESS, 4'hF);
    send_request(OP_CAPTURE, 4'h0);
    send_request(OP_CAPTURE, 4'h5);
    send_request(OP_CAPTURE, 4'hA);
    send_request(OP_CAPTURE, 4'hF);
    send_request(OP_PROCESS, 4'h0);
    send_request(OP_DISPLAY, 4'hF);
    send_request(OP_RELEASE, 4'hF);
    send_request(OP_RELEASE, 4'(FRAME_COUNT));
    send_request(OP_RELEASE, 4'h1);
    send_request(OP_RELEASE, 4'h1);
    send_request(OP_CAPTURE, 4'h3);
    send_request(OP_RELEASE, 4'h2);
    send_request(OP_DISPLAY, 4'hC);
    send_request(OP_PROCESS, 4'h6);
    send_request(OP_RELEASE, 4'h0);
    send_request(OP_RELEASE, 4'h1);
    send_request(OP_RELEASE, 4'h2);
    send_request(OP_RELEASE, 4'h8);
    send_request(OP_CAPTURE, 4'h9);
    send_request(OP_PROCESS, 4'hA);
    send_request(OP_DISPLAY, 4'h5);

    // Random phases: slow receiver, slow sender, then full rate
    tx_idle_pct = 9;
    rx_idle_pct = 66;
    repeat (ITEMS_PER_PHASE) send_random_request();
    tx_idle_pct = 66;
    rx_idle_pct = 9;
    repeat (ITEMS_PER_PHASE) send_random_request();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (ITEMS_PER_PHASE) send_random_request();
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then allow a few quiet cycles
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
